[hdl/plsm_pkg.sv]
// Package: shared widths, codes and controller/datapath handshake structs.
`timescale 1ns / 1ps
package plsm_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = 6;
    localparam int CNT_W       = 7;
    localparam int WORD_W      = 32;
    localparam int CFG_IDX_W   = 3;
    localparam int QUOT_W      = 41;
    localparam int PROD_W      = 66;
    localparam int DIV_CNT_W   = 6;

    typedef logic signed [WORD_W-1:0] word_t;

    // Operation codes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_MAP  = 1'b1;

    // Status codes
    localparam logic [1:0] ST_MAPPED = 2'd0;
    localparam logic [1:0] ST_LOADED = 2'd1;
    localparam logic [1:0] ST_FEW    = 2'd2;
    localparam logic [1:0] ST_SAT    = 2'd3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ABS_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ABS_OFFSET = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_EN     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_X      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_Y      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_EN     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_X      = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_Y      = 3'd7;

    // Table read address selects
    localparam logic [2:0] RD_MID = 3'd0;
    localparam logic [2:0] RD_LO  = 3'd1;
    localparam logic [2:0] RD_LM1 = 3'd2;
    localparam logic [2:0] RD_LM2 = 3'd3;
    localparam logic [2:0] RD_ONE = 3'd4;

    typedef struct packed {
        logic       capture;
        logic       do_load;
        logic       quick;
        logic       srch_init;
        logic       rd_en;
        logic [2:0] rd_sel;
        logic       cmp_step;
        logic       cap_a;
        logic       cap_b;
        logic       exact;
        logic       diff;
        logic       mag;
        logic       set_ay;
        logic       mul;
        logic       ovf;
        logic       div_init;
        logic       div_step;
        logic       sum;
        logic       out_load;
    } plsm_cmd_t;

    typedef struct packed {
        logic is_load;
        logic quick;
        logic lo_lt_hi;
        logic lo_eq_cnt;
        logic lo_zero;
        logic rd_eq_s;
        logic dx_zero;
        logic div_ovf;
        logic div_last;
    } plsm_sts_t;

endpackage

[hdl/plsm_if.sv]
// Interfaces: input word channel and result word channel.
`timescale 1ns / 1ps
interface plsm_in_if;
    logic                              valid;
    logic                              ready;
    logic                              op;
    logic [plsm_pkg::IDX_W-1:0]        entry_index;
    logic signed [plsm_pkg::WORD_W-1:0] entry_x;
    logic signed [plsm_pkg::WORD_W-1:0] entry_y;
    logic signed [plsm_pkg::WORD_W-1:0] score;

    modport source (output valid, op, entry_index, entry_x, entry_y, score, input ready);
    modport sink   (input valid, op, entry_index, entry_x, entry_y, score, output ready);
endinterface

interface plsm_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [plsm_pkg::WORD_W-1:0] weighted_score;
    logic [1:0]                        status;

    modport source (output valid, weighted_score, status, input ready);
    modport sink   (input valid, weighted_score, status, output ready);
endinterface

[hdl/plsm_datapath.sv]
// Datapath: registers, breakpoint memory, search bounds, multiplier and serial divider.
`timescale 1ns / 1ps
module plsm_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  plsm_pkg::plsm_cmd_t               cmd,
    output plsm_pkg::plsm_sts_t               sts,
    input  logic                              cfg_we,
    input  logic [plsm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [plsm_pkg::WORD_W-1:0]       cfg_data,
    input  logic                              in_op,
    input  logic [plsm_pkg::IDX_W-1:0]        in_entry_index,
    input  logic signed [plsm_pkg::WORD_W-1:0] in_entry_x,
    input  logic signed [plsm_pkg::WORD_W-1:0] in_entry_y,
    input  logic signed [plsm_pkg::WORD_W-1:0] in_score,
    output logic signed [plsm_pkg::WORD_W-1:0] out_weighted_score,
    output logic [1:0]                        out_status
);
    import plsm_pkg::*;

    localparam word_t W_MAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam word_t W_MIN = {1'b1, {(WORD_W-1){1'b0}}};

    // Configuration
    logic  abs_mode_reg, min_en_reg, max_en_reg;
    word_t abs_off_reg, min_x_reg, min_y_reg, max_x_reg, max_y_reg;

    // Item and table state
    logic              op_reg;
    logic [IDX_W-1:0]  idx_reg;
    word_t             ex_reg, ey_reg, s_reg;
    logic [CNT_W-1:0]  count_reg;
    word_t             mem_x [TABLE_DEPTH];
    word_t             mem_y [TABLE_DEPTH];
    word_t             rd_x_reg, rd_y_reg;
    logic [CNT_W-1:0]  lo_reg, hi_reg, mid_reg;
    logic [CNT_W:0]    mid_sum;
    logic [CNT_W-1:0]  mid;
    logic [IDX_W-1:0]  rd_addr;

    // Interpolation
    word_t                 ax_reg, ay_reg, bx_reg, by_reg;
    logic signed [WORD_W:0] dx_reg, dy_reg, ds_reg;
    logic [WORD_W:0]       mdx_reg, mdy_reg, mds_reg;
    logic                  neg_reg;
    logic [PROD_W-1:0]     prod_reg;
    logic [WORD_W:0]       rem_reg;
    logic [QUOT_W-1:0]     low_reg, q_reg;
    logic [DIV_CNT_W-1:0]  dcnt_reg;
    logic [WORD_W+1:0]     trial, trial_sub;

    // Result staging
    word_t      res_reg;
    logic [1:0] rsts_reg;

    // Quick path
    logic signed [WORD_W:0] abs_sum;
    word_t                  abs_clip;
    logic                   abs_sat, max_hit, min_hit, few;
    logic signed [WORD_W+10:0] fin_sum;
    logic                   fin_hi, fin_lo;

    // Write configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            abs_mode_reg <= 1'b0;
            abs_off_reg  <= '0;
            min_en_reg   <= 1'b0;
            min_x_reg    <= '0;
            min_y_reg    <= '0;
            max_en_reg   <= 1'b0;
            max_x_reg    <= '0;
            max_y_reg    <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ABS_MODE:   abs_mode_reg <= cfg_data[0];
                REG_ABS_OFFSET: abs_off_reg  <= cfg_data;
                REG_MIN_EN:     min_en_reg   <= cfg_data[0];
                REG_MIN_X:      min_x_reg    <= cfg_data;
                REG_MIN_Y:      min_y_reg    <= cfg_data;
                REG_MAX_EN:     max_en_reg   <= cfg_data[0];
                REG_MAX_X:      max_x_reg    <= cfg_data;
                REG_MAX_Y:      max_y_reg    <= cfg_data;
                default:        abs_mode_reg <= abs_mode_reg;
            endcase
        end
    end

    // Hold entry count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (cmd.do_load)
            count_reg <= {1'b0, idx_reg} + CNT_W'(1);
    end

    // Capture the input word
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg  <= in_op;
            idx_reg <= in_entry_index;
            ex_reg  <= in_entry_x;
            ey_reg  <= in_entry_y;
            s_reg   <= in_score;
        end
    end

    // Select the table read address
    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid     = mid_sum[CNT_W:1];

    always_comb
    begin
        case (cmd.rd_sel)
            RD_MID:  rd_addr = mid[IDX_W-1:0];
            RD_LO:   rd_addr = lo_reg[IDX_W-1:0];
            RD_LM1:  rd_addr = lo_reg[IDX_W-1:0] - IDX_W'(1);
            RD_LM2:  rd_addr = lo_reg[IDX_W-1:0] - IDX_W'(2);
            RD_ONE:  rd_addr = IDX_W'(1);
            default: rd_addr = lo_reg[IDX_W-1:0];
        endcase
    end

    // Breakpoint memory: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (cmd.do_load)
        begin
            mem_x[idx_reg] <= ex_reg;
            mem_y[idx_reg] <= ey_reg;
        end
        if (cmd.rd_en)
        begin
            rd_x_reg <= mem_x[rd_addr];
            rd_y_reg <= mem_y[rd_addr];
        end
    end

    // Advance the binary search bounds
    always_ff @(posedge clk)
    begin
        if (cmd.srch_init)
        begin
            lo_reg <= '0;
            hi_reg <= count_reg;
        end
        else if (cmd.cmp_step)
        begin
            if (rd_x_reg < s_reg)
                lo_reg <= mid_reg + CNT_W'(1);
            else
                hi_reg <= mid_reg;
        end
        if (cmd.rd_en && cmd.rd_sel == RD_MID)
            mid_reg <= mid;
    end

    // Capture the two line points
    always_ff @(posedge clk)
    begin
        if (cmd.cap_a)
        begin
            ax_reg <= rd_x_reg;
            ay_reg <= rd_y_reg;
        end
        if (cmd.cap_b)
        begin
            bx_reg <= rd_x_reg;
            by_reg <= rd_y_reg;
        end
    end

    // Differences, magnitudes, product
    always_ff @(posedge clk)
    begin
        if (cmd.diff)
        begin
            dx_reg <= {bx_reg[WORD_W-1], bx_reg} - {ax_reg[WORD_W-1], ax_reg};
            dy_reg <= {by_reg[WORD_W-1], by_reg} - {ay_reg[WORD_W-1], ay_reg};
            ds_reg <= {s_reg[WORD_W-1], s_reg} - {ax_reg[WORD_W-1], ax_reg};
        end
        if (cmd.mag)
        begin
            mdx_reg <= dx_reg[WORD_W] ? -dx_reg : dx_reg;
            mdy_reg <= dy_reg[WORD_W] ? -dy_reg : dy_reg;
            mds_reg <= ds_reg[WORD_W] ? -ds_reg : ds_reg;
            neg_reg <= ds_reg[WORD_W] ^ dy_reg[WORD_W] ^ dx_reg[WORD_W];
        end
        if (cmd.mul)
            prod_reg <= PROD_W'(mds_reg) * PROD_W'(mdy_reg);
    end

    // Restoring division, one quotient bit per cycle
    assign trial     = {rem_reg, low_reg[QUOT_W-1]};
    assign trial_sub = trial - {1'b0, mdx_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.div_init)
        begin
            rem_reg  <= (WORD_W+1)'(prod_reg[PROD_W-1:QUOT_W]);
            low_reg  <= prod_reg[QUOT_W-1:0];
            q_reg    <= '0;
            dcnt_reg <= DIV_CNT_W'(QUOT_W - 1);
        end
        else if (cmd.div_step)
        begin
            if (!trial_sub[WORD_W+1])
                rem_reg <= trial_sub[WORD_W:0];
            else
                rem_reg <= trial[WORD_W:0];
            low_reg  <= {low_reg[QUOT_W-2:0], 1'b0};
            q_reg    <= {q_reg[QUOT_W-2:0], ~trial_sub[WORD_W+1]};
            dcnt_reg <= dcnt_reg - DIV_CNT_W'(1);
        end
    end

    // Quick answers: absolute, clamps, short table
    assign abs_sum  = {s_reg[WORD_W-1], s_reg} + {abs_off_reg[WORD_W-1], abs_off_reg};
    assign abs_sat  = abs_sum[WORD_W] != abs_sum[WORD_W-1];
    assign abs_clip = abs_sat ? (abs_sum[WORD_W] ? W_MIN : W_MAX) : abs_sum[WORD_W-1:0];
    assign max_hit  = max_en_reg && (s_reg > max_x_reg);
    assign min_hit  = min_en_reg && (s_reg < min_x_reg);
    assign few      = count_reg < CNT_W'(2);

    // Final sum and clip
    assign fin_sum = neg_reg
        ? (WORD_W+11)'(ay_reg) - $signed({2'b00, q_reg})
        : (WORD_W+11)'(ay_reg) + $signed({2'b00, q_reg});
    assign fin_hi  = !fin_sum[WORD_W+10] && (|fin_sum[WORD_W+9:WORD_W-1]);
    assign fin_lo  = fin_sum[WORD_W+10] && !(&fin_sum[WORD_W+9:WORD_W-1]);

    // Stage the result
    always_ff @(posedge clk)
    begin
        if (cmd.do_load)
        begin
            res_reg  <= '0;
            rsts_reg <= ST_LOADED;
        end
        else if (cmd.quick)
        begin
            if (abs_mode_reg)
            begin
                res_reg  <= abs_clip;
                rsts_reg <= abs_sat ? ST_SAT : ST_MAPPED;
            end
            else if (max_hit)
            begin
                res_reg  <= max_y_reg;
                rsts_reg <= ST_MAPPED;
            end
            else if (min_hit)
            begin
                res_reg  <= min_y_reg;
                rsts_reg <= ST_MAPPED;
            end
            else
            begin
                res_reg  <= '0;
                rsts_reg <= ST_FEW;
            end
        end
        else if (cmd.exact)
        begin
            res_reg  <= rd_y_reg;
            rsts_reg <= ST_MAPPED;
        end
        else if (cmd.set_ay)
        begin
            res_reg  <= ay_reg;
            rsts_reg <= ST_MAPPED;
        end
        else if (cmd.ovf)
        begin
            res_reg  <= neg_reg ? W_MIN : W_MAX;
            rsts_reg <= ST_SAT;
        end
        else if (cmd.sum)
        begin
            if (fin_hi)
                res_reg <= W_MAX;
            else if (fin_lo)
                res_reg <= W_MIN;
            else
                res_reg <= fin_sum[WORD_W-1:0];
            rsts_reg <= (fin_hi || fin_lo) ? ST_SAT : ST_MAPPED;
        end
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_weighted_score <= res_reg;
            out_status         <= rsts_reg;
        end
    end

    // Report status to the controller
    always_comb
    begin
        sts.is_load   = (op_reg == OP_LOAD);
        sts.quick     = abs_mode_reg || max_hit || min_hit || few;
        sts.lo_lt_hi  = lo_reg < hi_reg;
        sts.lo_eq_cnt = lo_reg == count_reg;
        sts.lo_zero   = lo_reg == '0;
        sts.rd_eq_s   = rd_x_reg == s_reg;
        sts.dx_zero   = mdx_reg == '0;
        sts.div_ovf   = (WORD_W+1)'(prod_reg[PROD_W-1:QUOT_W]) >= mdx_reg;
        sts.div_last  = dcnt_reg == '0;
    end

endmodule

[hdl/plsm_ctrl.sv]
// Controller: state machine sequencing search, interpolation and handshakes.
`timescale 1ns / 1ps
module plsm_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output plsm_pkg::plsm_cmd_t cmd,
    input  plsm_pkg::plsm_sts_t sts
);
    import plsm_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DECIDE = 4'd1;
    localparam logic [3:0] S_SRCH   = 4'd2;
    localparam logic [3:0] S_CMP    = 4'd3;
    localparam logic [3:0] S_CHK    = 4'd4;
    localparam logic [3:0] S_GETAE  = 4'd5;
    localparam logic [3:0] S_GETA   = 4'd6;
    localparam logic [3:0] S_GETB   = 4'd7;
    localparam logic [3:0] S_DIFF   = 4'd8;
    localparam logic [3:0] S_MAG    = 4'd9;
    localparam logic [3:0] S_MUL    = 4'd10;
    localparam logic [3:0] S_DIV0   = 4'd11;
    localparam logic [3:0] S_DIV    = 4'd12;
    localparam logic [3:0] S_SUM    = 4'd13;
    localparam logic [3:0] S_FIN    = 4'd14;

    logic [3:0] state_reg, state_next;
    logic       ovalid_reg, ovalid_next;

    // Advance state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = ovalid_reg;

    // Next state and commands
    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        ovalid_next = ovalid_reg && !out_ready;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (sts.is_load)
                begin
                    cmd.do_load = 1'b1;
                    state_next  = S_FIN;
                end
                else if (sts.quick)
                begin
                    cmd.quick  = 1'b1;
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.srch_init = 1'b1;
                    state_next    = S_SRCH;
                end
            end
            S_SRCH:
            begin
                cmd.rd_en = 1'b1;
                if (sts.lo_lt_hi)
                begin
                    cmd.rd_sel = RD_MID;
                    state_next = S_CMP;
                end
                else if (sts.lo_eq_cnt)
                begin
                    cmd.rd_sel = RD_LM2;
                    state_next = S_GETAE;
                end
                else
                begin
                    cmd.rd_sel = RD_LO;
                    state_next = S_CHK;
                end
            end
            S_CMP:
            begin
                cmd.cmp_step = 1'b1;
                state_next   = S_SRCH;
            end
            S_GETAE:
            begin
                cmd.cap_a  = 1'b1;
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_LM1;
                state_next = S_GETB;
            end
            S_CHK:
            begin
                if (sts.rd_eq_s)
                begin
                    cmd.exact  = 1'b1;
                    state_next = S_FIN;
                end
                else if (sts.lo_zero)
                begin
                    cmd.cap_a  = 1'b1;
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_ONE;
                    state_next = S_GETB;
                end
                else
                begin
                    cmd.cap_b  = 1'b1;
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_LM1;
                    state_next = S_GETA;
                end
            end
            S_GETA:
            begin
                cmd.cap_a  = 1'b1;
                state_next = S_DIFF;
            end
            S_GETB:
            begin
                cmd.cap_b  = 1'b1;
                state_next = S_DIFF;
            end
            S_DIFF:
            begin
                cmd.diff   = 1'b1;
                state_next = S_MAG;
            end
            S_MAG:
            begin
                cmd.mag    = 1'b1;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                if (sts.dx_zero)
                begin
                    cmd.set_ay = 1'b1;
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.mul    = 1'b1;
                    state_next = S_DIV0;
                end
            end
            S_DIV0:
            begin
                if (sts.div_ovf)
                begin
                    cmd.ovf    = 1'b1;
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.div_init = 1'b1;
                    state_next   = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                    state_next = S_SUM;
            end
            S_SUM:
            begin
                cmd.sum    = 1'b1;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                // Hand the word to the output register once it is free
                if (!ovalid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    ovalid_next  = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

[hdl/piecewise_linear_score_map.sv]
// Flow: a word is captured, then loads, absolute mode, clamps and short tables are answered in
// S_DECIDE. Table queries use binary-search probes on the single memory read port (up to 7),
// then line-point reads, arithmetic and serial division; S_FIN fills the output register.
// Throughput: one word in flight; the next word is taken while a result waits in the
// output register. Reset clears control, configuration and entry count; table is unset.
`timescale 1ns / 1ps
module piecewise_linear_score_map (
    input  logic                           clk,
    input  logic                           rst_n,
    plsm_in_if.sink                        in_ch,
    plsm_out_if.source                     out_ch,
    input  logic                           cfg_we,
    input  logic [plsm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [plsm_pkg::WORD_W-1:0]    cfg_data
);
    import plsm_pkg::*;

    plsm_cmd_t cmd;
    plsm_sts_t sts;

    plsm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    plsm_datapath u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .sts                (sts),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .in_op              (in_ch.op),
        .in_entry_index     (in_ch.entry_index),
        .in_entry_x         (in_ch.entry_x),
        .in_entry_y         (in_ch.entry_y),
        .in_score           (in_ch.score),
        .out_weighted_score (out_ch.weighted_score),
        .out_status         (out_ch.status)
    );

endmodule

[bench/tb_top.sv]
// Testbench for the score map: predicts every result word and checks it at the output.
`timescale 1ns / 1ps
module tb_top;
    import plsm_pkg::*;

    typedef struct {
        logic                op;
        logic [IDX_W-1:0]    idx;
        logic [WORD_W-1:0]   x;
        logic [WORD_W-1:0]   y;
        logic [WORD_W-1:0]   s;
    } entry_word_t;

    typedef struct {
        logic [WORD_W-1:0] ws;
        logic [1:0]        st;
    } mapped_word_t;

    localparam longint WORD_MAX = 64'sd2147483647;
    localparam longint WORD_MIN = -64'sd2147483648;
    localparam int     DRAIN_CYCLES = 100;
    localparam int     STALL_LIMIT  = 20000;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [WORD_W-1:0] cfg_data;

    plsm_in_if  in_ch ();
    plsm_out_if out_ch ();

    piecewise_linear_score_map i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    // Predictor state: configuration and breakpoint table
    logic        m_abs;
    longint      m_offset;
    logic        m_min_en;
    longint      m_min_x;
    longint      m_min_y;
    logic        m_max_en;
    longint      m_max_x;
    longint      m_max_y;
    logic [WORD_W-1:0] m_tx [TABLE_DEPTH];
    logic [WORD_W-1:0] m_ty [TABLE_DEPTH];
    int          m_count;

    entry_word_t  pending_q [$];
    mapped_word_t mapped_q [$];
    int           errors;
    int           send_idle;
    int           recv_idle;
    int           stall_cycles;

    // Generator view of the table, to keep reads on written entries only
    int           gen_hi;
    int           gen_x [TABLE_DEPTH];

    function automatic longint clip_word(longint v, ref bit sat);
        if (v > WORD_MAX)
        begin
            sat = 1'b1;
            return WORD_MAX;
        end
        if (v < WORD_MIN)
        begin
            sat = 1'b1;
            return WORD_MIN;
        end
        return v;
    endfunction

    function automatic longint bp_x(int i);
        return longint'($signed(m_tx[i % TABLE_DEPTH]));
    endfunction

    function automatic longint bp_y(int i);
        return longint'($signed(m_ty[i % TABLE_DEPTH]));
    endfunction

    function automatic longint interpolate(longint ax, longint ay, longint bx, longint by,
                                           longint s, ref bit sat);
        longint dx;
        longint dy;
        longint ds;
        logic [63:0] q;
        bit neg;
        dx = bx - ax;
        dy = by - ay;
        ds = s - ax;
        if (dx == 0)
            return clip_word(ay, sat);
        neg = ((ds < 0) != (dy < 0)) != (dx < 0);
        // Magnitudes are unsigned so the full 64-bit product divides correctly
        q = ($unsigned(ds < 0 ? -ds : ds) * $unsigned(dy < 0 ? -dy : dy))
            / $unsigned(dx < 0 ? -dx : dx);
        if (q > 64'h100_0000_0000)
        begin
            sat = 1'b1;
            return neg ? WORD_MIN : WORD_MAX;
        end
        return clip_word(ay + (neg ? -longint'(q) : longint'(q)), sat);
    endfunction

    // Work out the result word of one input word and advance the table
    function automatic mapped_word_t map_score(entry_word_t w);
        mapped_word_t res;
        longint r;
        longint s;
        bit sat;
        int lo;
        int hi;
        int mid;
        r = 0;
        sat = 1'b0;
        res.st = ST_MAPPED;
        if (w.op == OP_LOAD)
        begin
            m_tx[w.idx] = w.x;
            m_ty[w.idx] = w.y;
            m_count = int'(w.idx) + 1;
            res.st = ST_LOADED;
        end
        else
        begin
            s = longint'($signed(w.s));
            if (m_abs)
                r = clip_word(s + m_offset, sat);
            else if (m_max_en && s > m_max_x)
                r = m_max_y;
            else if (m_min_en && s < m_min_x)
                r = m_min_y;
            else if (m_count < 2)
                res.st = ST_FEW;
            else
            begin
                lo = 0;
                hi = m_count;
                while (lo < hi)
                begin
                    mid = (lo + hi) / 2;
                    if (bp_x(mid) < s)
                        lo = mid + 1;
                    else
                        hi = mid;
                end
                if (lo == m_count)
                    r = interpolate(bp_x(lo - 2), bp_y(lo - 2), bp_x(lo - 1), bp_y(lo - 1),
                                    s, sat);
                else if (bp_x(lo) == s)
                    r = bp_y(lo);
                else if (lo == 0)
                    r = interpolate(bp_x(0), bp_y(0), bp_x(1), bp_y(1), s, sat);
                else
                    r = interpolate(bp_x(lo - 1), bp_y(lo - 1), bp_x(lo), bp_y(lo), s, sat);
            end
            if (sat)
                res.st = ST_SAT;
        end
        res.ws = r[WORD_W-1:0];
        return res;
    endfunction

    task automatic report(string what, logic [WORD_W-1:0] got, logic [WORD_W-1:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // Drive input words from the pending queue, predicting each accepted word
    always @(posedge clk)
    begin
        entry_word_t w;
        if (rst_n)
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                w.op = in_ch.op;
                w.idx = in_ch.entry_index;
                w.x = in_ch.entry_x;
                w.y = in_ch.entry_y;
                w.s = in_ch.score;
                mapped_q = {mapped_q, map_score(w)};
            end
            if (!in_ch.valid || in_ch.ready)
            begin
                if (pending_q.size() > 0 && $urandom_range(99) >= send_idle)
                begin
                    w = pending_q.pop_front();
                    in_ch.valid <= 1'b1;
                    in_ch.op <= w.op;
                    in_ch.entry_index <= w.idx;
                    in_ch.entry_x <= w.x;
                    in_ch.entry_y <= w.y;
                    in_ch.score <= w.s;
                end
                else
                    in_ch.valid <= 1'b0;
            end
        end
    end

    // Accept result words and compare against the oldest prediction
    always @(posedge clk)
    begin
        mapped_word_t want;
        if (rst_n)
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (mapped_q.size() == 0)
                    report("unexpected word", out_ch.weighted_score, '0);
                else
                begin
                    want = mapped_q.pop_front();
                    if (out_ch.weighted_score !== want.ws)
                        report("weighted_score", out_ch.weighted_score, want.ws);
                    if (out_ch.status !== want.st)
                        report("status", 32'(out_ch.status), 32'(want.st));
                end
            end
            out_ch.ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // Watchdog: give up when nothing moves for too long
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            REG_ABS_MODE:   m_abs = val[0];
            REG_ABS_OFFSET: m_offset = longint'($signed(val));
            REG_MIN_EN:     m_min_en = val[0];
            REG_MIN_X:      m_min_x = longint'($signed(val));
            REG_MIN_Y:      m_min_y = longint'($signed(val));
            REG_MAX_EN:     m_max_en = val[0];
            REG_MAX_X:      m_max_x = longint'($signed(val));
            default:        m_max_y = longint'($signed(val));
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic push_load(int idx, logic [WORD_W-1:0] x, logic [WORD_W-1:0] y);
        entry_word_t w;
        w.op = OP_LOAD;
        w.idx = IDX_W'(idx);
        w.x = x;
        w.y = y;
        w.s = $urandom;
        pending_q = {pending_q, w};
        gen_x[idx] = int'(x);
        if (idx > gen_hi)
            gen_hi = idx;
    endtask

    task automatic push_query(logic [WORD_W-1:0] s);
        entry_word_t w;
        w.op = OP_MAP;
        w.idx = IDX_W'($urandom);
        w.x = $urandom;
        w.y = $urandom;
        w.s = s;
        pending_q = {pending_q, w};
    endtask

    // Wait until every word is through, then let the block settle
    task automatic drain;
        do
            @(negedge clk);
        while (pending_q.size() > 0 || mapped_q.size() > 0 || in_ch.valid);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [WORD_W-1:0] pick_value();
        case ($urandom_range(5))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return $urandom;
            default: return 32'($signed($urandom_range(400000)) - 200000);
        endcase
    endfunction

    // Load a sorted table of n entries starting at index 0
    task automatic load_table(int n);
        int xs [];
        int spread;
        xs = new[n];
        spread = ($urandom_range(3) == 0) ? 0 : $urandom_range(1 << 20, 1);
        foreach (xs[i])
        begin
            if (spread == 0)
                xs[i] = int'($urandom);
            else
                xs[i] = int'($urandom_range(spread)) - spread / 2;
        end
        if ($urandom_range(3) == 0 && n > 2)
            xs[1] = xs[0];
        xs.sort();
        foreach (xs[i])
            push_load(i, xs[i], ($urandom_range(1) == 0) ? pick_value() : $urandom);
    endtask

    function automatic logic [WORD_W-1:0] pick_score();
        int k;
        k = $urandom_range(gen_hi < 0 ? 0 : gen_hi);
        case ($urandom_range(7))
            0:       return $urandom;
            1:       return 32'h8000_0000;
            2:       return 32'h7fff_ffff;
            3:       return gen_x[k];
            default: return gen_x[k] + int'($urandom_range(4000)) - 2000;
        endcase
    endfunction

    task automatic random_config;
        cfg_write(REG_ABS_MODE, $urandom_range(99) < 15);
        cfg_write(REG_ABS_OFFSET, pick_value());
        cfg_write(REG_MIN_EN, $urandom_range(1));
        cfg_write(REG_MIN_X, pick_value());
        cfg_write(REG_MIN_Y, pick_value());
        cfg_write(REG_MAX_EN, $urandom_range(1));
        cfg_write(REG_MAX_X, pick_value());
        cfg_write(REG_MAX_Y, pick_value());
    endtask

    initial
    begin
        int sent;
        int pick;
        int n;
        errors = 0;
        stall_cycles = 0;
        gen_hi = -1;
        m_abs = 1'b0;
        m_offset = 0;
        m_min_en = 1'b0;
        m_min_x = 0;
        m_min_y = 0;
        m_max_en = 1'b0;
        m_max_x = 0;
        m_max_y = 0;
        m_count = 0;
        send_idle = 37;
        recv_idle = 66;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.op = OP_LOAD;
        in_ch.entry_index = '0;
        in_ch.entry_x = '0;
        in_ch.entry_y = '0;
        in_ch.score = '0;
        out_ch.ready = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty and one-entry table, then lookup cases
        push_query(32'h0000_1000);
        push_load(0, 32'h8000_0000, 32'h7fff_ffff);
        push_query(32'h8000_0000);
        push_load(0, -32'sd65536, 32'sd0);
        push_load(1, 32'sd0, 32'sd65536);
        push_load(2, 32'sd65536, 32'sd262144);
        push_load(3, 32'sd65536, 32'sd5);
        push_load(4, 32'sd131072, -32'sd131072);
        push_query(32'sd0);
        push_query(32'sd32768);
        push_query(-32'sd200000);
        push_query(32'sd200000);
        push_query(32'h8000_0000);
        push_query(32'h7fff_ffff);
        push_query(32'sd65536);
        push_load(2, 32'sd65536, 32'h7fff_0000);
        push_query(32'h7fff_ffff);
        push_query(32'sd40000);
        drain();

        // Directed: absolute mode and both clamps at their extremes
        cfg_write(REG_ABS_MODE, 1);
        cfg_write(REG_ABS_OFFSET, 32'h7fff_ffff);
        push_query(32'h7fff_ffff);
        push_query(32'h8000_0000);
        drain();
        cfg_write(REG_ABS_OFFSET, 32'h8000_0000);
        push_query(32'h8000_0000);
        push_query(32'h7fff_ffff);
        drain();
        cfg_write(REG_ABS_MODE, 0);
        cfg_write(REG_MAX_EN, 1);
        cfg_write(REG_MAX_X, 32'sd0);
        cfg_write(REG_MAX_Y, 32'h7fff_ffff);
        cfg_write(REG_MIN_EN, 1);
        cfg_write(REG_MIN_X, -32'sd100);
        cfg_write(REG_MIN_Y, 32'h8000_0000);
        push_query(32'sd1);
        push_query(32'sd0);
        push_query(-32'sd101);
        push_query(-32'sd100);
        drain();

        // Random segments, idling profile changes every two segments
        for (int seg = 0; seg < 5; seg++)
        begin
            send_idle = (seg < 2) ? 37 : (seg < 4) ? 66 : 0;
            recv_idle = (seg < 2) ? 66 : (seg < 4) ? 37 : 0;
            random_config();
            sent = 0;
            while (sent < 250)
            begin
                pick = $urandom_range(99);
                if (pick < 12 || gen_hi < 1)
                begin
                    n = ($urandom_range(19) == 0) ? TABLE_DEPTH : $urandom_range(10, 2);
                    load_table(n);
                    sent += n;
                end
                else if (pick < 22)
                begin
                    push_load($urandom_range(gen_hi + 1 > TABLE_DEPTH - 1 ? TABLE_DEPTH - 1
                                                                     : gen_hi + 1),
                              pick_value(), $urandom);
                    sent++;
                end
                else
                begin
                    push_query(pick_score());
                    sent++;
                end
            end
            drain();
        end

        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
